### rtl/core/fxfb_pkg.sv
// ----------------------------------------------------------------------------
// fxfb_pkg
// Shared types and constants of the fragmenting XOR frame builder.
// ----------------------------------------------------------------------------
package fxfb_pkg;

	localparam logic [7:0] START_BYTE = 8'h02;
	localparam logic [7:0] DATA_CMD   = 8'h04;

	localparam int CFG_W   = 16;
	localparam int CFG_IDX_W = 1;

	// register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_MAX_PAYLOAD  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_OPEN = 1'd1;

	localparam logic [15:0] MAX_PAYLOAD_RST = 16'd128;

	// input item commands
	localparam logic CMD_BEGIN = 1'b0;
	localparam logic CMD_DATA  = 1'b1;

	typedef struct packed {
		logic        cmd;
		logic [15:0] message_length;
		logic [7:0]  data_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       frame_end;
		logic       message_end;
		logic       last_of_run;
	} out_item_t;

	// one classified payload byte, handed from front end to back end
	typedef struct packed {
		logic [7:0]  data_byte;
		logic        hdr;        // frame header goes out first
		logic [15:0] chunk_len;  // length carried in the header
		logic        ck;         // checksum follows the byte
		logic [7:0]  ck_byte;
		logic        msg_end;
	} job_t;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_START,
		PH_CMD,
		PH_LEN_LO,
		PH_LEN_HI,
		PH_DATA,
		PH_CHECK
	} phase_t;

endpackage

### rtl/core/fxfb_front.sv
// ----------------------------------------------------------------------------
// fxfb_front
// Accepts requests, tracks message and chunk progress and the frame XOR,
// and turns each payload byte that is due into one job.
// ----------------------------------------------------------------------------
module fxfb_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               take,
	input  fxfb_pkg::in_item_t in_item,
	input  logic [15:0]        max_payload,
	input  logic               channel_open,
	output logic               job_we,
	output fxfb_pkg::job_t     job
);

	logic [15:0] bytes_remaining_q;
	logic [15:0] chunk_left_q;
	logic [7:0]  running_xor_q;

	logic        is_data;
	logic        new_frame;
	logic [15:0] lim;
	logic [15:0] sz;
	logic [15:0] chunk_nxt;
	logic [15:0] rem_nxt;
	logic [7:0]  xor_base;
	logic [7:0]  xor_nxt;

	always_comb begin
		lim       = (max_payload == 16'd0) ? 16'd1 : max_payload;
		sz        = (bytes_remaining_q <= lim) ? bytes_remaining_q : lim;
		new_frame = (chunk_left_q == 16'd0);
		chunk_nxt = (new_frame ? sz : chunk_left_q) - 16'd1;
		rem_nxt   = bytes_remaining_q - 16'd1;
		xor_base  = new_frame ?
			(fxfb_pkg::START_BYTE ^ fxfb_pkg::DATA_CMD ^ sz[7:0] ^ sz[15:8]) :
			running_xor_q;
		xor_nxt   = xor_base ^ in_item.data_byte;
		is_data   = take && channel_open && (in_item.cmd == fxfb_pkg::CMD_DATA) &&
			(bytes_remaining_q != 16'd0);

		job_we        = is_data;
		job.data_byte = in_item.data_byte;
		job.hdr       = new_frame;
		job.chunk_len = sz;
		job.ck        = (chunk_nxt == 16'd0);
		job.ck_byte   = xor_nxt;
		job.msg_end   = (rem_nxt == 16'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_remaining_q <= '0;
			chunk_left_q      <= '0;
			running_xor_q     <= '0;
		end else if (take && channel_open) begin
			if (in_item.cmd == fxfb_pkg::CMD_BEGIN) begin
				bytes_remaining_q <= in_item.message_length;
				chunk_left_q      <= '0;
				running_xor_q     <= '0;
			end else if (is_data) begin
				bytes_remaining_q <= rem_nxt;
				chunk_left_q      <= chunk_nxt;
				running_xor_q     <= (chunk_nxt == 16'd0) ? 8'd0 : xor_nxt;
			end
		end
	end

endmodule

### rtl/core/fxfb_job_fifo.sv
// ----------------------------------------------------------------------------
// fxfb_job_fifo
// Small show-ahead queue of jobs between front end and back end.
// ----------------------------------------------------------------------------
module fxfb_job_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             we,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	output logic [WIDTH-1:0] rdata,
	output logic             not_empty,
	output logic             full
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
	localparam logic [AW:0]   FULL_CNT = (AW+1)'(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [AW:0]      count_q;
	logic             do_wr;
	logic             do_rd;

	assign not_empty = (count_q != '0);
	assign full      = (count_q == FULL_CNT);
	assign rdata     = mem_q[rd_ptr_q];
	assign do_wr     = we && !full;
	assign do_rd     = re && not_empty;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### rtl/core/fxfb_back.sv
// ----------------------------------------------------------------------------
// fxfb_back
// Plays out a job as header (if it opens a frame), payload byte and checksum
// (if it closes one) into the result register, one byte a cycle while popped.
// ----------------------------------------------------------------------------
module fxfb_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                job_valid,
	input  fxfb_pkg::job_t      job,
	output logic                job_pop,
	output logic                empty,
	input  logic                pop,
	output fxfb_pkg::out_item_t out_item
);

	fxfb_pkg::phase_t    phase_q;
	fxfb_pkg::phase_t    phase_nxt;
	fxfb_pkg::phase_t    cur;
	fxfb_pkg::out_item_t out_q;
	fxfb_pkg::out_item_t item;
	logic                out_valid_q;
	logic                load;
	logic                emit;
	logic                last;

	assign load     = !out_valid_q || pop;
	assign emit     = job_valid && load;
	assign empty    = !out_valid_q;
	assign out_item = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= fxfb_pkg::PH_IDLE;
		end else begin
			phase_q <= phase_nxt;
		end
	end

	always_comb begin
		cur = phase_q;
		if (phase_q == fxfb_pkg::PH_IDLE) begin
			cur = job.hdr ? fxfb_pkg::PH_START : fxfb_pkg::PH_DATA;
		end

		item.out_byte    = job.data_byte;
		item.frame_end   = 1'b0;
		item.message_end = 1'b0;
		last             = 1'b0;
		case (cur)
			fxfb_pkg::PH_START:  item.out_byte = fxfb_pkg::START_BYTE;
			fxfb_pkg::PH_CMD:    item.out_byte = fxfb_pkg::DATA_CMD;
			fxfb_pkg::PH_LEN_LO: item.out_byte = job.chunk_len[7:0];
			fxfb_pkg::PH_LEN_HI: item.out_byte = job.chunk_len[15:8];
			fxfb_pkg::PH_DATA: begin
				item.out_byte = job.data_byte;
				last          = !job.ck;
			end
			fxfb_pkg::PH_CHECK: begin
				item.out_byte    = job.ck_byte;
				item.frame_end   = 1'b1;
				item.message_end = job.msg_end;
				last             = 1'b1;
			end
			default: item.out_byte = job.data_byte;
		endcase
		item.last_of_run = last;

		phase_nxt = phase_q;
		job_pop   = 1'b0;
		if (emit) begin
			if (last) begin
				phase_nxt = fxfb_pkg::PH_IDLE;
				job_pop   = 1'b1;
			end else begin
				case (cur)
					fxfb_pkg::PH_START:  phase_nxt = fxfb_pkg::PH_CMD;
					fxfb_pkg::PH_CMD:    phase_nxt = fxfb_pkg::PH_LEN_LO;
					fxfb_pkg::PH_LEN_LO: phase_nxt = fxfb_pkg::PH_LEN_HI;
					fxfb_pkg::PH_LEN_HI: phase_nxt = fxfb_pkg::PH_DATA;
					fxfb_pkg::PH_DATA:   phase_nxt = fxfb_pkg::PH_CHECK;
					default:             phase_nxt = fxfb_pkg::PH_IDLE;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q <= item;
		end
	end

endmodule

### rtl/core/fragmenting_xor_frame_builder.sv
// ----------------------------------------------------------------------------
// fragmenting_xor_frame_builder
// Cuts announced messages into data-send frames with an XOR checksum.
// ----------------------------------------------------------------------------
// A begin request (cmd 0) announces a message length; each payload request
// (cmd 1) then adds one byte. Bytes are cut into chunks of at most
// max_payload bytes (0 acts as 1), and every chunk leaves as one frame:
// 0x02, 0x04, length low, length high, payload, XOR of all earlier frame
// bytes. The header comes out with a chunk's first byte, the checksum with
// its last. Requests taken while channel_open is 0 are ignored; nothing comes
// out for a zero-length message or for bytes past the announced length; a
// begin mid-message drops the old message and leaves its open frame unclosed.
// Rate: a request is taken every cycle while the job queue (JOB_DEPTH entries)
// has room, and the front end settles its state in that same cycle. The back
// end sends one result byte a cycle while results are popped, so a payload
// byte yields 1 to 6 result bytes (6 when it opens and closes a frame);
// output bandwidth sets the sustained rate. Write configuration only while no
// results are pending.
// ----------------------------------------------------------------------------
module fragmenting_xor_frame_builder #(
	parameter int JOB_DEPTH = 4
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// request side
	input  logic                                push,
	output logic                                full,
	input  fxfb_pkg::in_item_t                  in_item,
	// result side
	output logic                                empty,
	input  logic                                pop,
	output fxfb_pkg::out_item_t                 out_item,
	// configuration
	input  logic                                cfg_we,
	input  logic [fxfb_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [fxfb_pkg::CFG_W-1:0]          cfg_data
);

	logic [15:0]    max_payload_q;
	logic           channel_open_q;

	logic           take;
	logic           job_we;
	fxfb_pkg::job_t job_in;
	fxfb_pkg::job_t job_head;
	logic           job_valid;
	logic           job_pop;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_payload_q  <= fxfb_pkg::MAX_PAYLOAD_RST;
			channel_open_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				fxfb_pkg::REG_MAX_PAYLOAD:  max_payload_q  <= cfg_data[15:0];
				fxfb_pkg::REG_CHANNEL_OPEN: channel_open_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// full mirrors the job queue; dropped requests still need a free slot
	assign take = push && !full;

	fxfb_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.take         (take),
		.in_item      (in_item),
		.max_payload  (max_payload_q),
		.channel_open (channel_open_q),
		.job_we       (job_we),
		.job          (job_in)
	);

	fxfb_job_fifo #(
		.WIDTH ($bits(fxfb_pkg::job_t)),
		.DEPTH (JOB_DEPTH)
	) u_job_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.we        (job_we),
		.wdata     (job_in),
		.re        (job_pop),
		.rdata     (job_head),
		.not_empty (job_valid),
		.full      (full)
	);

	fxfb_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (job_valid),
		.job       (job_head),
		.job_pop   (job_pop),
		.empty     (empty),
		.pop       (pop),
		.out_item  (out_item)
	);

endmodule
